[rtl/wall_near_clip_project_assert.svh]
// assertion macros shared by the wall clip rtl
`ifndef WALL_NEAR_CLIP_PROJECT_ASSERT_SVH
`define WALL_NEAR_CLIP_PROJECT_ASSERT_SVH
`ifndef SYNTH
`define WNC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wnc: implication check failed");
`define WNC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wnc: next cycle check failed");
`else
`define WNC_ASSERT_IMP(label, clk, rst, ante, cons)
`define WNC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/wnc_pkg.sv]
package wnc_pkg;

   localparam int MAX_SCREEN = 2048;

   // clip ratio divider, Q0.30 result
   localparam int CLIP_BITS = 30;
   localparam int CLIP_LAT  = CLIP_BITS + 1;

   // projection divider
   localparam int NUM_W    = 49;
   localparam int MAG_W    = NUM_W - 1;
   localparam int DEN_W    = 32;
   localparam int QBITS    = 23;
   localparam int CMP_W    = DEN_W + QBITS;
   localparam int QUO_W    = QBITS + 2;
   localparam int PROJ_LAT = QBITS + 2;

   typedef enum logic [2:0] {
      CSR_CAMERA_X      = 3'd0,
      CSR_CAMERA_Y      = 3'd1,
      CSR_CAMERA_Z      = 3'd2,
      CSR_VIEW_DIR_X    = 3'd3,
      CSR_VIEW_DIR_Y    = 3'd4,
      CSR_NEAR_LIMIT    = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6,
      CSR_SCREEN_HEIGHT = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_AWAY    = 2'd0,
      ST_NEAR    = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_DRAW    = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [31:0] end_a_x;
      logic signed [31:0] end_a_y;
      logic signed [31:0] end_b_x;
      logic signed [31:0] end_b_y;
      logic signed [31:0] ceiling_level;
      logic signed [31:0] floor_level;
      logic [11:0]        window_left;
      logic [11:0]        window_right;
      logic               is_portal;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               swapped;
      logic signed [15:0] left_column;
      logic signed [15:0] right_column;
      logic signed [15:0] left_top_row;
      logic signed [15:0] left_bottom_row;
      logic signed [15:0] right_top_row;
      logic signed [15:0] right_bottom_row;
      logic signed [31:0] left_depth;
      logic signed [31:0] right_depth;
      logic [11:0]        next_window_left;
      logic [11:0]        next_window_right;
   } rsp_type;

endpackage

[rtl/wnc_clip_div.sv]
module wnc_clip_div (
   input  logic                          clock,
   input  logic [31:0]                   num,
   input  logic [31:0]                   den,
   output logic [wnc_pkg::CLIP_BITS-1:0] ratio
);
   import wnc_pkg::*;

   // fraction num/den with num below den, one quotient bit per stage
   logic [31:0]          rem_ff [CLIP_BITS+1];
   logic [31:0]          den_ff [CLIP_BITS+1];
   logic [CLIP_BITS-1:0] quo_ff [CLIP_BITS+1];
   logic [31:0]          rem_in [CLIP_BITS];
   logic [CLIP_BITS-1:0] quo_in [CLIP_BITS];
   logic [32:0]          dbl    [CLIP_BITS];
   logic                 take   [CLIP_BITS];

   always_comb begin
      for (int k = 0; k < CLIP_BITS; k++) begin
         dbl[k]    = {rem_ff[k], 1'b0};
         take[k]   = dbl[k] >= {1'b0, den_ff[k]};
         rem_in[k] = take[k] ? 32'(dbl[k] - {1'b0, den_ff[k]}) : dbl[k][31:0];
         quo_in[k] = {quo_ff[k][CLIP_BITS-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      for (int k = 0; k < CLIP_BITS; k++) begin
         rem_ff[k+1] <= rem_in[k];
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= quo_in[k];
      end
   end

   assign ratio = quo_ff[CLIP_BITS];

endmodule

[rtl/wnc_proj_div.sv]
module wnc_proj_div (
   input  logic                               clock,
   input  logic signed [wnc_pkg::NUM_W-1:0]   num,
   input  logic signed [wnc_pkg::DEN_W-1:0]   den,
   output logic signed [wnc_pkg::QUO_W-1:0]   quo
);
   import wnc_pkg::*;

   localparam logic [QUO_W-1:0] SAT = QUO_W'(1) << QBITS;

   // sign and magnitude setup
   logic [MAG_W-1:0] mag_n_in;
   logic [DEN_W-1:0] mag_d_in;
   logic             neg_in;
   logic             sat_in;

   logic [MAG_W-1:0] rem_ff  [QBITS+1];
   logic [DEN_W-1:0] den_ff  [QBITS+1];
   logic [QBITS-1:0] qb_ff   [QBITS+1];
   logic             neg_ff  [QBITS+1];
   logic             sat_ff  [QBITS+1];
   logic [MAG_W-1:0] rem_in  [QBITS];
   logic [QBITS-1:0] qb_in   [QBITS];
   logic [CMP_W-1:0] shifted [QBITS];
   logic             take    [QBITS];
   logic [QUO_W-1:0] qmag;
   logic [QUO_W-1:0] quo_in;
   logic [QUO_W-1:0] quo_ff;

   always_comb begin
      mag_n_in = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
      mag_d_in = den[DEN_W-1] ? DEN_W'(-den) : den;
      neg_in   = num[NUM_W-1] ^ den[DEN_W-1];
      // zero divisor or quotient beyond range saturates
      sat_in   = (mag_d_in == '0) ||
                 (CMP_W'(mag_n_in) >= (CMP_W'(mag_d_in) << QBITS));
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      for (int k = 0; k < QBITS; k++) begin
         shifted[k] = CMP_W'(den_ff[k]) << (QBITS - 1 - k);
         take[k]    = CMP_W'(rem_ff[k]) >= shifted[k];
         rem_in[k]  = take[k] ? MAG_W'(CMP_W'(rem_ff[k]) - shifted[k]) : rem_ff[k];
         qb_in[k]   = qb_ff[k] | (take[k] ? (QBITS'(1) << (QBITS - 1 - k)) : '0);
      end
   end

   // saturation, sign, and floor for negative quotients
   always_comb begin
      qmag = QUO_W'(qb_ff[QBITS]);
      if (sat_ff[QBITS]) begin
         quo_in = neg_ff[QBITS] ? QUO_W'(-SAT) : SAT;
      end else if (neg_ff[QBITS]) begin
         quo_in = QUO_W'(-qmag - QUO_W'(rem_ff[QBITS] != '0));
      end else begin
         quo_in = qmag;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_n_in;
      den_ff[0] <= mag_d_in;
      qb_ff[0]  <= '0;
      neg_ff[0] <= neg_in;
      sat_ff[0] <= sat_in;
      for (int k = 0; k < QBITS; k++) begin
         rem_ff[k+1] <= rem_in[k];
         den_ff[k+1] <= den_ff[k];
         qb_ff[k+1]  <= qb_in[k];
         neg_ff[k+1] <= neg_ff[k];
         sat_ff[k+1] <= sat_ff[k];
      end
      quo_ff <= quo_in;
   end

   assign quo = $signed(quo_ff);

endmodule

[rtl/wall_near_clip_project.sv]
// wall_near_clip_project: clips one wall segment at the near distance and
// projects it to screen columns and rows.
//
// request channel: a wall segment is taken at a rising edge with start high
// and busy low. busy is high only while reset is held, so one request can be
// issued every cycle.
// result channel: rsp_strobe is high for one cycle with rsp_data; the
// receiver cannot hold results off and none is needed, results leave in
// request order.
// csr channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
// always high. write registers only while no request is in flight.
// one request per cycle is sustained; a request passes stages s1 to s6, the
// 31 stage clip ratio divider, stages s7 to s9, the 25 stage projection
// dividers and the output register.
// reset: synchronous, clears all pipeline valid bits and loads the default
// camera (origin, looking along +y, near 0.25, 320x200 screen).
`include "wall_near_clip_project_assert.svh"

module wall_near_clip_project (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  wnc_pkg::req_type       req_data,
   output logic                   rsp_strobe,
   output wnc_pkg::rsp_type       rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  wnc_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_data
);
   import wnc_pkg::*;

   // everything one wall carries down the pipe
   typedef struct packed {
      logic               valid;
      logic               away;
      logic               close;
      logic               portal;
      logic               swp;
      logic               clip_a;
      logic               clip_b;
      logic [11:0]        wl;
      logic [11:0]        wr;
      logic signed [32:0] hc;
      logic signed [32:0] hf;
      logic signed [31:0] da;
      logic signed [31:0] oa;
      logic signed [31:0] db;
      logic signed [31:0] ob;
      logic signed [32:0] diff;
   } pipe_type;

   localparam logic signed [35:0] DOT_MAX = 36'sh07fffffff;
   localparam logic signed [35:0] DOT_MIN = 36'shf80000000;

   function automatic logic signed [31:0] sat_dot(input logic signed [49:0] s);
      logic signed [35:0] f;
      f = s[49:14];
      if (f > DOT_MAX) return DOT_MAX[31:0];
      if (f < DOT_MIN) return DOT_MIN[31:0];
      return f[31:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [25:0] s);
      if (s > 26'sd32767) return 16'sh7fff;
      if (s < -26'sd32768) return 16'sh8000;
      return s[15:0];
   endfunction

   // ---------------------------------------------------------------- csr
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff;
   logic [30:0]        near_ff;
   logic [11:0]        width_ff, height_ff;
   logic signed [31:0] nearq;

   assign csr_ready = 1'b1;
   assign busy      = reset;
   assign nearq     = $signed({1'b0, near_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= '0;
         cam_y_ff  <= '0;
         cam_z_ff  <= '0;
         dir_x_ff  <= '0;
         dir_y_ff  <= 16'sd16384;
         near_ff   <= 31'd16384;
         width_ff  <= 12'd320;
         height_ff <= 12'd200;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAMERA_X:      cam_x_ff  <= csr_data;
            CSR_CAMERA_Y:      cam_y_ff  <= csr_data;
            CSR_CAMERA_Z:      cam_z_ff  <= csr_data;
            CSR_VIEW_DIR_X:    dir_x_ff  <= csr_data[15:0];
            CSR_VIEW_DIR_Y:    dir_y_ff  <= csr_data[15:0];
            CSR_NEAR_LIMIT:    near_ff   <= csr_data[30:0];
            CSR_SCREEN_WIDTH:  width_ff  <= csr_data[11:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- s1
   // camera relative endpoints and heights
   pipe_type           s1_in, s1_ff;
   logic signed [32:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_comb begin
      s1_in        = '0;
      s1_in.valid  = start && !busy;
      s1_in.portal = req_data.is_portal;
      s1_in.wl     = req_data.window_left;
      s1_in.wr     = req_data.window_right;
      s1_in.hc     = 33'(req_data.ceiling_level) - 33'(cam_z_ff);
      s1_in.hf     = 33'(req_data.floor_level) - 33'(cam_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff <= '0;
      else s1_ff <= s1_in;
      ax_ff <= 33'(req_data.end_a_x) - 33'(cam_x_ff);
      ay_ff <= 33'(req_data.end_a_y) - 33'(cam_y_ff);
      bx_ff <= 33'(req_data.end_b_x) - 33'(cam_x_ff);
      by_ff <= 33'(req_data.end_b_y) - 33'(cam_y_ff);
   end

   // ---------------------------------------------------------------- s2
   // eight dot product terms
   pipe_type           s2_ff;
   logic signed [48:0] dot_ff [8];

   always_ff @(posedge clock) begin
      if (reset) s2_ff <= '0;
      else s2_ff <= s1_ff;
      dot_ff[0] <= ax_ff * dir_x_ff;
      dot_ff[1] <= ay_ff * dir_y_ff;
      dot_ff[2] <= ax_ff * dir_y_ff;
      dot_ff[3] <= ay_ff * dir_x_ff;
      dot_ff[4] <= bx_ff * dir_x_ff;
      dot_ff[5] <= by_ff * dir_y_ff;
      dot_ff[6] <= bx_ff * dir_y_ff;
      dot_ff[7] <= by_ff * dir_x_ff;
   end

   // ---------------------------------------------------------------- s3
   // depth and side offset, floored and saturated
   pipe_type s3_in, s3_ff;

   always_comb begin
      s3_in    = s2_ff;
      s3_in.da = sat_dot(50'(dot_ff[0]) + 50'(dot_ff[1]));
      s3_in.oa = sat_dot(50'(dot_ff[2]) - 50'(dot_ff[3]));
      s3_in.db = sat_dot(50'(dot_ff[4]) + 50'(dot_ff[5]));
      s3_in.ob = sat_dot(50'(dot_ff[6]) - 50'(dot_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (reset) s3_ff <= '0;
      else s3_ff <= s3_in;
   end

   // ---------------------------------------------------------------- s4
   // early outs and the left/right cross products
   pipe_type           s4_in, s4_ff;
   logic signed [63:0] cross_a_ff, cross_b_ff;

   always_comb begin
      s4_in       = s3_ff;
      s4_in.away  = (s3_ff.da < 0) && (s3_ff.db < 0);
      s4_in.close = (s3_ff.da < nearq) && (s3_ff.db < nearq);
   end

   always_ff @(posedge clock) begin
      if (reset) s4_ff <= '0;
      else s4_ff <= s4_in;
      cross_a_ff <= s3_ff.oa * s3_ff.db;
      cross_b_ff <= s3_ff.ob * s3_ff.da;
   end

   // ---------------------------------------------------------------- s5
   // order endpoints left to right
   pipe_type s5_in, s5_ff;

   always_comb begin
      s5_in     = s4_ff;
      s5_in.swp = cross_a_ff > cross_b_ff;
      if (s5_in.swp) begin
         s5_in.da = s4_ff.db;
         s5_in.oa = s4_ff.ob;
         s5_in.db = s4_ff.da;
         s5_in.ob = s4_ff.oa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_ff <= '0;
      else s5_ff <= s5_in;
   end

   // ---------------------------------------------------------------- s6
   // pick the end to clip, form ratio operands
   pipe_type           s6_in, s6_ff;
   logic signed [31:0] dn, on, df, of;
   logic [31:0]        num_in, num_ff, den_in, den_ff;

   always_comb begin
      s6_in        = s5_ff;
      s6_in.clip_a = (s5_ff.da < nearq) && (s5_ff.db > nearq);
      s6_in.clip_b = (s5_ff.db < nearq) && (s5_ff.da > nearq);
      if (s6_in.clip_a) begin
         dn = s5_ff.da;
         on = s5_ff.oa;
         df = s5_ff.db;
         of = s5_ff.ob;
      end else begin
         dn = s5_ff.db;
         on = s5_ff.ob;
         df = s5_ff.da;
         of = s5_ff.oa;
      end
      num_in     = 32'(nearq) - 32'(dn);
      den_in     = 32'(df) - 32'(dn);
      s6_in.diff = 33'(of) - 33'(on);
   end

   always_ff @(posedge clock) begin
      if (reset) s6_ff <= '0;
      else s6_ff <= s6_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   // clip ratio divider and its side line
   logic [CLIP_BITS-1:0] ratio;
   pipe_type             cd_ff [CLIP_LAT];

   wnc_clip_div u_clip_div (
      .clock (clock),
      .num   (num_ff),
      .den   (den_ff),
      .ratio (ratio)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLIP_LAT; i++) cd_ff[i] <= '0;
      end else begin
         cd_ff[0] <= s6_ff;
         for (int i = 1; i < CLIP_LAT; i++) cd_ff[i] <= cd_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- s7
   pipe_type           s7_ff;
   logic signed [63:0] lerp_ff;

   always_ff @(posedge clock) begin
      if (reset) s7_ff <= '0;
      else s7_ff <= cd_ff[CLIP_LAT-1];
      lerp_ff <= cd_ff[CLIP_LAT-1].diff * $signed({1'b0, ratio});
   end

   // ---------------------------------------------------------------- s8
   // move the near end onto the clip distance
   pipe_type           s8_in, s8_ff;
   logic signed [63:0] onew;

   always_comb begin
      s8_in = s7_ff;
      onew  = 64'(s7_ff.clip_a ? s7_ff.oa : s7_ff.ob) + (lerp_ff >>> CLIP_BITS);
      if (s7_ff.clip_a) begin
         s8_in.da = nearq;
         s8_in.oa = onew[31:0];
      end else if (s7_ff.clip_b) begin
         s8_in.db = nearq;
         s8_in.ob = onew[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s8_ff <= '0;
      else s8_ff <= s8_in;
   end

   // ---------------------------------------------------------------- s9
   // projection numerators, scaled by screen height
   pipe_type           s9_ff;
   logic signed [45:0] n_ol_ff, n_or_ff, n_c_ff, n_f_ff;
   logic signed [12:0] hgt;

   assign hgt = $signed({1'b0, height_ff});

   always_ff @(posedge clock) begin
      if (reset) s9_ff <= '0;
      else s9_ff <= s8_ff;
      n_ol_ff <= s8_ff.oa * hgt;
      n_or_ff <= s8_ff.ob * hgt;
      n_c_ff  <= s8_ff.hc * hgt;
      n_f_ff  <= s8_ff.hf * hgt;
   end

   // six projection dividers
   logic signed [QUO_W-1:0] q_cl, q_cr, q_lt, q_lb, q_rt, q_rb;
   pipe_type                pd_ff [PROJ_LAT];

   wnc_proj_div u_div_cl (.clock(clock), .num({n_ol_ff, 3'b000}), .den(s9_ff.da), .quo(q_cl));
   wnc_proj_div u_div_cr (.clock(clock), .num({n_or_ff, 3'b000}), .den(s9_ff.db), .quo(q_cr));
   wnc_proj_div u_div_lt (.clock(clock), .num({n_c_ff, 3'b000}),  .den(s9_ff.da), .quo(q_lt));
   wnc_proj_div u_div_lb (.clock(clock), .num({n_f_ff, 3'b000}),  .den(s9_ff.da), .quo(q_lb));
   wnc_proj_div u_div_rt (.clock(clock), .num({n_c_ff, 3'b000}),  .den(s9_ff.db), .quo(q_rt));
   wnc_proj_div u_div_rb (.clock(clock), .num({n_f_ff, 3'b000}),  .den(s9_ff.db), .quo(q_rb));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PROJ_LAT; i++) pd_ff[i] <= '0;
      end else begin
         pd_ff[0] <= s9_ff;
         for (int i = 1; i < PROJ_LAT; i++) pd_ff[i] <= pd_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- out
   // screen offsets, window test and portal window
   pipe_type           so;
   logic signed [25:0] col_off, row_off, cl, cr, wl16, wr16, wl26, wr26, max26;
   logic signed [25:0] nl, nr;
   rsp_type            rsp_in, rsp_ff;
   logic               rsp_strobe_ff;

   always_comb begin
      so      = pd_ff[PROJ_LAT-1];
      col_off = $signed({11'b0, width_ff[11:1], 4'b0});
      row_off = $signed({11'b0, height_ff, 3'b0});
      cl      = 26'(q_cl) + col_off;
      cr      = 26'(q_cr) + col_off;
      wl16    = $signed({10'b0, so.wl, 4'b0});
      wr16    = $signed({10'b0, so.wr, 4'b0});
      wl26    = $signed({14'b0, so.wl});
      wr26    = $signed({14'b0, so.wr});
      max26   = 26'(MAX_SCREEN);

      // truncate toward zero to whole columns
      nl = (cl < 0) ? ((cl + 26'sd15) >>> 4) : (cl >>> 4);
      nr = (cr < 0) ? ((cr + 26'sd15) >>> 4) : (cr >>> 4);
      if (nl < wl26) nl = wl26;
      if (nr > wr26) nr = wr26;
      if (nl < 0) nl = '0;
      if (nl > max26) nl = max26;
      if (nr < 0) nr = '0;
      if (nr > max26) nr = max26;

      rsp_in = '0;
      if (so.away) begin
         rsp_in.status = ST_AWAY;
      end else if (so.close) begin
         rsp_in.status = ST_NEAR;
         if (so.portal) begin
            rsp_in.next_window_left  = so.wl;
            rsp_in.next_window_right = so.wr;
         end
      end else begin
         rsp_in.swapped          = so.swp;
         rsp_in.left_column      = sat16(cl);
         rsp_in.right_column     = sat16(cr);
         rsp_in.left_top_row     = sat16(26'(q_lt) + row_off);
         rsp_in.left_bottom_row  = sat16(26'(q_lb) + row_off);
         rsp_in.right_top_row    = sat16(26'(q_rt) + row_off);
         rsp_in.right_bottom_row = sat16(26'(q_rb) + row_off);
         rsp_in.left_depth       = so.da;
         rsp_in.right_depth      = so.db;
         if (so.portal) begin
            rsp_in.status            = ST_DRAW;
            rsp_in.next_window_left  = nl[11:0];
            rsp_in.next_window_right = nr[11:0];
         end else if (((cl > cr) ? cl : cr) < wl16 || ((cl < cr) ? cl : cr) >= wr16) begin
            rsp_in.status = ST_OUTSIDE;
         end else begin
            rsp_in.status = ST_DRAW;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= so.valid;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ---------------------------------------------------------------- checks
   `WNC_ASSERT_IMP(a_clip_reaches_near, clock, reset,
      s9_ff.valid && !s9_ff.away && !s9_ff.close,
      (s9_ff.da >= nearq) || (s9_ff.db >= nearq))
   `WNC_ASSERT_IMP(a_away_all_zero, clock, reset,
      rsp_strobe && rsp_data.status == ST_AWAY,
      rsp_data.left_depth == 0 && rsp_data.right_depth == 0 && !rsp_data.swapped)
   `WNC_ASSERT_IMP(a_outside_no_window, clock, reset,
      rsp_strobe && rsp_data.status == ST_OUTSIDE,
      rsp_data.next_window_left == 0 && rsp_data.next_window_right == 0)
   `WNC_ASSERT_NXT(a_reset_flushes, clock, 1'b0,
      reset,
      !rsp_strobe && !s1_ff.valid)

endmodule

[test/tb_wall_near_clip_project.sv]
module tb_wall_near_clip_project;
   import wnc_pkg::*;

   // one world unit in Q16.16
   localparam longint UNIT = 65536;
   // cycles with nothing accepted before the run is declared hung
   localparam int HANG_LIMIT = 3000;
   // settle time after the last result, covers the pipeline depth
   localparam int TAIL_CYCLES = 100;

   typedef enum logic [1:0] {OP_REQ, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type   kind;
      req_type       wall;
      csr_index_type idx;
      logic [31:0]   val;
   } pending_op_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_data;
   logic          rsp_strobe;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [31:0]   csr_data;

   wall_near_clip_project dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow copy of the camera registers, updated on each accepted write
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic signed [15:0] dir_x, dir_y;
   logic [30:0]        near_dist;
   logic [11:0]        scr_w, scr_h;

   pending_op_type pending_ops[$];
   rsp_type        projected_walls[$];

   // camera position as scheduled, used to aim generated walls at the camera
   longint cam_proxy_x, cam_proxy_y, cam_proxy_z;

   // handshake results of the last rising edge, read by the driver
   bit req_taken, csr_taken;
   int gap_left;
   bit burst_mode;

   int n_requests, n_results, n_csr, n_mismatch, hang_count;
   int status_seen[4];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // projection divide, a zero depth saturates toward the numerator sign
   function automatic longint proj_div(longint n, longint d);
      if (d == 0) return n >= 0 ? (longint'(1) <<< 40) : -(longint'(1) <<< 40);
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      return floor_div(n, d);
   endfunction

   // Q.30 dot product brought back to Q16.16, saturated to 32 bits
   function automatic longint view_dot(longint dx, longint dy, longint ux, longint uy);
      return clamp(floor_div(dx * ux + dy * uy, 16384), -(longint'(1) <<< 31),
                   (longint'(1) <<< 31) - 1);
   endfunction

   // pull the near end onto the clip distance, offset follows a Q0.30 ratio
   function automatic void clip_to_near(inout longint dn, inout longint on,
                                        input longint df, input longint off,
                                        input longint nearq);
      longint ratio;
      ratio = ((nearq - dn) <<< 30) / (df - dn);
      on = on + floor_div((off - on) * ratio, longint'(1) <<< 30);
      dn = nearq;
   endfunction

   function automatic rsp_type project_wall(req_type r);
      rsp_type p;
      longint ux, uy, nearq, w, h, ax, ay, bx, by, wl, wr;
      longint da, db, oa, ob, tmp, cl, cr, nl, nr, ch, fh;
      longint rows[4];
      p = '0;
      ux = dir_x;
      uy = dir_y;
      nearq = longint'(near_dist);
      w = longint'(scr_w);
      h = longint'(scr_h);
      ax = longint'(r.end_a_x) - longint'(cam_x);
      ay = longint'(r.end_a_y) - longint'(cam_y);
      bx = longint'(r.end_b_x) - longint'(cam_x);
      by = longint'(r.end_b_y) - longint'(cam_y);
      wl = longint'(r.window_left);
      wr = longint'(r.window_right);
      nl = 0;
      nr = 0;
      da = view_dot(ax, ay, ux, uy);
      db = view_dot(bx, by, ux, uy);
      oa = view_dot(ax, ay, uy, -ux);
      ob = view_dot(bx, by, uy, -ux);

      // whole wall behind the eye
      if (da < 0 && db < 0) begin
         p.status = ST_AWAY;
         return p;
      end
      // whole wall inside the near distance
      if ((da > db ? da : db) < nearq) begin
         p.status = ST_NEAR;
         if (r.is_portal) begin
            p.next_window_left  = r.window_left;
            p.next_window_right = r.window_right;
         end
         return p;
      end

      // order ends left to right by cross product of offset and depth
      if (oa * db > ob * da) begin
         p.swapped = 1'b1;
         tmp = da; da = db; db = tmp;
         tmp = oa; oa = ob; ob = tmp;
      end
      // clip only when one end is strictly in front of and one strictly past the limit
      if (da < nearq && db > nearq) clip_to_near(da, oa, db, ob, nearq);
      else if (db < nearq && da > nearq) clip_to_near(db, ob, da, oa, nearq);

      ch = longint'(r.ceiling_level) - longint'(cam_z);
      fh = longint'(r.floor_level) - longint'(cam_z);
      cl = proj_div(oa * 8 * h, da) + (w >>> 1) * 16;
      cr = proj_div(ob * 8 * h, db) + (w >>> 1) * 16;
      rows[0] = proj_div(ch * 8 * h, da) + h * 8;
      rows[1] = proj_div(fh * 8 * h, da) + h * 8;
      rows[2] = proj_div(ch * 8 * h, db) + h * 8;
      rows[3] = proj_div(fh * 8 * h, db) + h * 8;

      if (r.is_portal) begin
         // columns truncated to whole pixels, then narrowed to the open window
         p.status = ST_DRAW;
         nl = cl / 16;
         if (nl < wl) nl = wl;
         nr = cr / 16;
         if (nr > wr) nr = wr;
         nl = clamp(nl, 0, MAX_SCREEN);
         nr = clamp(nr, 0, MAX_SCREEN);
      end else if ((cl > cr ? cl : cr) < wl * 16 || (cl < cr ? cl : cr) >= wr * 16) begin
         p.status = ST_OUTSIDE;
      end else begin
         p.status = ST_DRAW;
      end

      p.left_column       = 16'(clamp(cl, -32768, 32767));
      p.right_column      = 16'(clamp(cr, -32768, 32767));
      p.left_top_row      = 16'(clamp(rows[0], -32768, 32767));
      p.left_bottom_row   = 16'(clamp(rows[1], -32768, 32767));
      p.right_top_row     = 16'(clamp(rows[2], -32768, 32767));
      p.right_bottom_row  = 16'(clamp(rows[3], -32768, 32767));
      p.left_depth        = 32'(da);
      p.right_depth       = 32'(db);
      p.next_window_left  = 12'(nl);
      p.next_window_right = 12'(nr);
      return p;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   task automatic add_wall(longint ax, longint ay, longint bx, longint by, longint ceil_h,
                           longint floor_h, int wl, int wr, bit portal);
      pending_op_type op;
      op.kind = OP_REQ;
      op.wall.end_a_x       = 32'(ax);
      op.wall.end_a_y       = 32'(ay);
      op.wall.end_b_x       = 32'(bx);
      op.wall.end_b_y       = 32'(by);
      op.wall.ceiling_level = 32'(ceil_h);
      op.wall.floor_level   = 32'(floor_h);
      op.wall.window_left   = 12'(wl);
      op.wall.window_right  = 12'(wr);
      op.wall.is_portal     = portal;
      pending_ops.push_back(op);
   endtask

   // register writes always come after a full drain of the pipeline
   task automatic add_csr(csr_index_type idx, logic [31:0] val);
      pending_op_type op;
      op.kind = OP_DRAIN;
      pending_ops.push_back(op);
      op.kind = OP_CSR;
      op.idx  = idx;
      op.val  = val;
      pending_ops.push_back(op);
   endtask

   // coordinate near a base point, spread over +-span world units
   function automatic longint near_coord(longint base, int span);
      return base + longint'($urandom_range(0, 2 * span * 65536)) - longint'(span) * UNIT;
   endfunction

   // random gaps: mostly none or short, a few long, with gap-free bursts
   function automatic int pick_gap();
      int roll;
      if ($urandom_range(0, 60) == 0) burst_mode = ~burst_mode;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one camera setup and a batch of walls around it
   task automatic random_phase(int n_walls);
      longint bx0, by0;
      int span, wl, wr;
      int sel;
      pending_op_type op;
      sel = $urandom_range(0, 9);
      // camera placement: mostly moderate, sometimes anywhere
      if (sel == 0) begin
         add_csr(CSR_CAMERA_X, $urandom);
         add_csr(CSR_CAMERA_Y, $urandom);
         add_csr(CSR_CAMERA_Z, $urandom);
      end else begin
         add_csr(CSR_CAMERA_X, 32'(near_coord(0, 1000)));
         add_csr(CSR_CAMERA_Y, 32'(near_coord(0, 1000)));
         add_csr(CSR_CAMERA_Z, 32'(near_coord(0, 8)));
      end
      // view direction: axes, diagonals, or an arbitrary non-unit vector
      case ($urandom_range(0, 4))
         0: begin
            add_csr(CSR_VIEW_DIR_X, 32'(16384));
            add_csr(CSR_VIEW_DIR_Y, 32'(0));
         end
         1: begin
            add_csr(CSR_VIEW_DIR_X, 32'(-16384));
            add_csr(CSR_VIEW_DIR_Y, 32'(0));
         end
         2: begin
            add_csr(CSR_VIEW_DIR_X, 32'(-11585));
            add_csr(CSR_VIEW_DIR_Y, 32'(-11585));
         end
         3: begin
            add_csr(CSR_VIEW_DIR_X, 32'(11585));
            add_csr(CSR_VIEW_DIR_Y, 32'(-11585));
         end
         default: begin
            add_csr(CSR_VIEW_DIR_X, $urandom);
            add_csr(CSR_VIEW_DIR_Y, $urandom);
         end
      endcase
      case ($urandom_range(0, 5))
         0: add_csr(CSR_NEAR_LIMIT, 32'h0);
         1: add_csr(CSR_NEAR_LIMIT, 32'h7fff_ffff);
         2: add_csr(CSR_NEAR_LIMIT, $urandom);
         default: add_csr(CSR_NEAR_LIMIT, $urandom_range(1, 4 * 65536));
      endcase
      case ($urandom_range(0, 5))
         0: add_csr(CSR_SCREEN_WIDTH, 32'd1);
         1: add_csr(CSR_SCREEN_WIDTH, 32'd2048);
         2: add_csr(CSR_SCREEN_WIDTH, $urandom);
         default: add_csr(CSR_SCREEN_WIDTH, $urandom_range(64, 1024));
      endcase
      case ($urandom_range(0, 5))
         0: add_csr(CSR_SCREEN_HEIGHT, 32'd1);
         1: add_csr(CSR_SCREEN_HEIGHT, 32'd2048);
         2: add_csr(CSR_SCREEN_HEIGHT, $urandom);
         default: add_csr(CSR_SCREEN_HEIGHT, $urandom_range(64, 1024));
      endcase
      op.kind = OP_DRAIN;
      pending_ops.push_back(op);

      // walls: mostly around the camera, with full-range noise mixed in
      for (int i = 0; i < n_walls; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            op.kind = OP_REQ;
            op.wall = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       12'($urandom), 12'($urandom), 1'($urandom)};
            pending_ops.push_back(op);
         end else begin
            span = ($urandom_range(0, 3) == 0) ? 2 : 30;
            bx0 = cam_proxy_x;
            by0 = cam_proxy_y;
            wl = $urandom_range(0, 2048);
            wr = $urandom_range(0, 2048);
            if ($urandom_range(0, 3) != 0 && wl > wr) begin
               sel = wl; wl = wr; wr = sel;
            end
            add_wall(near_coord(bx0, span), near_coord(by0, span), near_coord(bx0, span),
                     near_coord(by0, span), near_coord(cam_proxy_z, 6),
                     near_coord(cam_proxy_z, 6), wl, wr, 1'($urandom));
         end
         // now and then hold the sender until the pipeline is empty
         if ($urandom_range(0, 199) == 0) begin
            op.kind = OP_DRAIN;
            pending_ops.push_back(op);
         end
      end
   endtask

   // tracks the camera writes as they are queued so walls land near it
   function automatic void note_camera();
      cam_proxy_x = 0;
      cam_proxy_y = 0;
      cam_proxy_z = 0;
      foreach (pending_ops[i]) begin
         if (pending_ops[i].kind == OP_CSR) begin
            if (pending_ops[i].idx == CSR_CAMERA_X)
               cam_proxy_x = longint'(signed'(pending_ops[i].val));
            if (pending_ops[i].idx == CSR_CAMERA_Y)
               cam_proxy_y = longint'(signed'(pending_ops[i].val));
            if (pending_ops[i].idx == CSR_CAMERA_Z)
               cam_proxy_z = longint'(signed'(pending_ops[i].val));
         end
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      bit start_n, csr_n;
      start_n = start;
      csr_n = csr_valid;
      if (!reset) begin
         if (start && !req_taken) begin
            // request still waiting for acceptance
         end else if (csr_valid && !csr_taken) begin
            // register write still waiting
         end else begin
            start_n = 1'b0;
            csr_n = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_ops.size() > 0) begin
               case (pending_ops[0].kind)
                  OP_REQ: begin
                     req_data <= pending_ops[0].wall;
                     start_n = 1'b1;
                     void'(pending_ops.pop_front());
                     gap_left = pick_gap();
                  end
                  OP_CSR: begin
                     if (projected_walls.size() == 0) begin
                        csr_index <= pending_ops[0].idx;
                        csr_data <= pending_ops[0].val;
                        csr_n = 1'b1;
                        void'(pending_ops.pop_front());
                     end
                  end
                  default: begin
                     // drain point: wait for every outstanding result
                     if (projected_walls.size() == 0) void'(pending_ops.pop_front());
                  end
               endcase
            end
         end
      end
      start <= start_n;
      csr_valid <= csr_n;
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cam_x = '0;
         cam_y = '0;
         cam_z = '0;
         dir_x = 16'sd0;
         dir_y = 16'sd16384;
         near_dist = 31'd16384;
         scr_w = 12'd320;
         scr_h = 12'd200;
         req_taken = 1'b0;
         csr_taken = 1'b0;
         hang_count = 0;
      end else begin
         req_taken = start && !busy;
         csr_taken = csr_valid && csr_ready;
         if (req_taken || csr_taken || rsp_strobe) hang_count = 0;
         else hang_count++;

         // a result goes out before a new request of the same edge is predicted
         if (rsp_strobe) begin
            n_results++;
            if (projected_walls.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = projected_walls.pop_front();
               if (rsp_data.status !== want.status || rsp_data.swapped !== want.swapped ||
                   rsp_data.left_column !== want.left_column ||
                   rsp_data.right_column !== want.right_column ||
                   rsp_data.left_top_row !== want.left_top_row ||
                   rsp_data.left_bottom_row !== want.left_bottom_row ||
                   rsp_data.right_top_row !== want.right_top_row ||
                   rsp_data.right_bottom_row !== want.right_bottom_row ||
                   rsp_data.left_depth !== want.left_depth ||
                   rsp_data.right_depth !== want.right_depth ||
                   rsp_data.next_window_left !== want.next_window_left ||
                   rsp_data.next_window_right !== want.next_window_right) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("mismatch on result %0d\n  expected %p\n  actual   %p",
                              n_results, want, rsp_data);
               end
            end
         end

         if (req_taken) begin
            want = project_wall(req_data);
            status_seen[want.status]++;
            projected_walls.push_back(want);
            n_requests++;
         end

         if (csr_taken) begin
            n_csr++;
            case (csr_index)
               CSR_CAMERA_X:      cam_x = csr_data;
               CSR_CAMERA_Y:      cam_y = csr_data;
               CSR_CAMERA_Z:      cam_z = csr_data;
               CSR_VIEW_DIR_X:    dir_x = csr_data[15:0];
               CSR_VIEW_DIR_Y:    dir_y = csr_data[15:0];
               CSR_NEAR_LIMIT:    near_dist = csr_data[30:0];
               CSR_SCREEN_WIDTH:  scr_w = csr_data[11:0];
               default:           scr_h = csr_data[11:0];
            endcase
         end

         if (hang_count >= HANG_LIMIT) begin
            $display("no progress for %0d cycles", HANG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      pending_op_type op;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_CAMERA_X;
      csr_data = '0;
      req_data = '0;
      gap_left = 0;
      burst_mode = 1'b0;

      // directed walls under the reset camera: eye at origin looking along +y,
      // so depth is y and side offset is x
      add_wall(-UNIT, -2 * UNIT, UNIT, -2 * UNIT, UNIT, -UNIT, 0, 320, 0);      // behind
      add_wall(-UNIT, UNIT / 10, UNIT, UNIT / 10, UNIT, -UNIT, 0, 320, 0);      // too near
      add_wall(-UNIT, UNIT / 10, UNIT, UNIT / 10, UNIT, -UNIT, 5, 300, 1);      // near portal
      add_wall(-2 * UNIT, 5 * UNIT, 2 * UNIT, 5 * UNIT, UNIT, -UNIT, 0, 320, 0); // plain draw
      add_wall(2 * UNIT, 5 * UNIT, -2 * UNIT, 5 * UNIT, UNIT, -UNIT, 0, 320, 0); // swapped
      add_wall(-UNIT, -UNIT, UNIT, 5 * UNIT, UNIT, -UNIT, 0, 320, 0);           // clip left end
      add_wall(UNIT, 5 * UNIT, 2 * UNIT, -3 * UNIT, UNIT, -UNIT, 0, 320, 1);    // clip right end
      add_wall(-UNIT, UNIT / 4, UNIT, UNIT / 10, UNIT, -UNIT, 0, 320, 0);       // depth on limit
      add_wall(-UNIT, UNIT / 4, UNIT, 4 * UNIT, UNIT, -UNIT, 0, 320, 0);        // on limit, far end
      add_wall(-50 * UNIT, 5 * UNIT, -40 * UNIT, 5 * UNIT, UNIT, -UNIT, 100, 200, 0); // left out
      add_wall(40 * UNIT, 5 * UNIT, 50 * UNIT, 5 * UNIT, UNIT, -UNIT, 100, 200, 0);   // right out
      add_wall(-40 * UNIT, 5 * UNIT, 40 * UNIT, 5 * UNIT, UNIT, -UNIT, 50, 100, 1);   // portal narrow
      add_wall(-40 * UNIT, 5 * UNIT, 40 * UNIT, 5 * UNIT, UNIT, -UNIT, 3000, 4095, 1); // odd window
      add_wall(0, 0, 0, 0, 0, 0, 0, 0, 0);                                     // all zero
      add_wall(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 4095, 4095, 1);
      add_wall(-(longint'(1) <<< 31), -(longint'(1) <<< 31), -(longint'(1) <<< 31),
               -(longint'(1) <<< 31), -(longint'(1) <<< 31), -(longint'(1) <<< 31), 0, 0, 0);
      add_wall(-(longint'(1) <<< 31), 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               -(longint'(1) <<< 31), 32'h7fff_ffff, 0, 4095, 1);
      // zero depth with no near distance: the divide saturates
      add_csr(CSR_NEAR_LIMIT, 32'h0);
      add_wall(0, 0, UNIT, 5 * UNIT, UNIT, -UNIT, 0, 320, 0);
      add_wall(-UNIT, 0, UNIT, 0, 0, -UNIT, 0, 320, 1);
      add_wall(-UNIT, 0, UNIT, 5 * UNIT, UNIT, -UNIT, 0, 320, 0);
      // largest near distance: everything falls inside it
      add_csr(CSR_NEAR_LIMIT, 32'h7fff_ffff);
      add_wall(-UNIT, 1000 * UNIT, UNIT, 1000 * UNIT, UNIT, -UNIT, 0, 320, 1);
      // restore the default clip
      add_csr(CSR_NEAR_LIMIT, 32'd16384);

      // random phases, each with its own camera setup
      for (int ph = 0; ph < 12; ph++) begin
         random_phase(0);
         // walls aim at the camera that this phase just scheduled
         note_camera();
         void'(pending_ops.pop_back());
         op.kind = OP_DRAIN;
         pending_ops.push_back(op);
         random_phase_walls_only(100);
      end

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // everything sent and answered
      do @(posedge clock);
      while (pending_ops.size() != 0 || start || csr_valid || projected_walls.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d walls and %0d register writes, checked %0d results",
               n_requests, n_csr, n_results);
      $display("status mix: away %0d, near %0d, outside %0d, draw %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (n_mismatch == 0 && projected_walls.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch,
                  projected_walls.size());
         $display("== FAIL ==");
      end
      $finish;
   end

   // walls for the current phase without touching the camera setup
   task automatic random_phase_walls_only(int n_walls);
      pending_op_type op;
      int span, wl, wr, t;
      for (int i = 0; i < n_walls; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            op.kind = OP_REQ;
            op.wall = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       12'($urandom), 12'($urandom), 1'($urandom)};
            pending_ops.push_back(op);
         end else begin
            span = ($urandom_range(0, 3) == 0) ? 2 : 30;
            wl = $urandom_range(0, 2048);
            wr = $urandom_range(0, 2048);
            if ($urandom_range(0, 3) != 0 && wl > wr) begin
               t = wl; wl = wr; wr = t;
            end
            add_wall(near_coord(cam_proxy_x, span), near_coord(cam_proxy_y, span),
                     near_coord(cam_proxy_x, span), near_coord(cam_proxy_y, span),
                     near_coord(cam_proxy_z, 6), near_coord(cam_proxy_z, 6), wl, wr,
                     1'($urandom));
         end
         // now and then hold the sender until the pipeline is empty
         if ($urandom_range(0, 199) == 0) begin
            op.kind = OP_DRAIN;
            pending_ops.push_back(op);
         end
      end
   endtask

endmodule

[filelist.f]
+incdir+rtl
rtl/wnc_pkg.sv
rtl/wnc_clip_div.sv
rtl/wnc_proj_div.sv
rtl/wall_near_clip_project.sv
test/tb_wall_near_clip_project.sv
